### rtl/core/nrmc_pkg.sv
package nrmc_pkg;

    // Longest sentence that can still be accepted, in bytes.
    localparam int MAX_SENTENCE_LEN = 128;
    localparam int POS_W            = $clog2(MAX_SENTENCE_LEN + 1);
    localparam int TIME_CHARS       = 6;
    localparam int TIME_FIRST_POS   = 7;

    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_ACTIVE = 8'h41;

    // "$GPRMC"
    localparam logic [7:0] LEAD_TEXT [6] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

    // Hours in a day; the local hour wraps at this value.
    localparam logic [7:0] HOURS_PER_DAY = 8'd24;

    // Reset value of the zone offset register.
    localparam logic [4:0] ZONE_OFFSET_RESET = 5'd8;

    typedef struct packed {
        logic [7:0] sentence_byte;
        logic       final_byte;
    } nrmc_in_t;

    typedef struct packed {
        logic       sentence_accepted;
        logic       time_known;
        logic [4:0] local_hour;
        logic [6:0] local_minute;
        logic [6:0] local_second;
    } nrmc_out_t;

    // Verdict handed from the sentence scanner to the time holder on a final byte.
    typedef struct packed {
        logic                           finish;
        logic                           accepted;
        logic [TIME_CHARS-1:0][3:0]     digits;
    } nrmc_verdict_t;

endpackage

### rtl/core/nmea_rmc_checksum_time_parser_unit.sv
// NMEA 0183 $GPRMC checker and local-time holder. Sentence bytes arrive one per
// transaction on the input channel, with final_byte set on the last byte of each
// sentence. The block checks that the sentence opens with "$GPRMC", that the byte
// after the second comma is 'A', and that the XOR of the bytes between '$' and the
// first '*' equals the hexadecimal value written after the '*'. Every final byte
// produces exactly one output transaction; other bytes produce none. When all checks
// pass, the held time is replaced by the hhmmss characters at byte positions 7 to 12,
// with the hour advanced by the zone offset and wrapped modulo 24; the output
// always carries the held time and whether any sentence has been accepted since
// reset. The block takes one byte every clock cycle unless its input stalls: a byte
// passes an input register and one stage of per-byte update logic, and the result
// of a final byte is then registered. The input stalls only when a result is
// waiting in the output register and the next final byte would need that register.
// The zone offset is written through the configuration channel, which is always
// ready, and should only be changed while no sentence is in flight; it resets to 8.
module nmea_rmc_checksum_time_parser_unit
    import nrmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  nrmc_in_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output nrmc_out_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data
);

    // Input register: holds one byte while the scanner works on it.
    logic       stage_valid_reg;
    nrmc_in_t   stage_data_reg;
    logic [4:0] zone_offset_reg;
    logic       step;

    nrmc_verdict_t verdict;

    // A byte leaves the input register unless it is a final byte and the output
    // register still holds a result that the consumer has not taken.
    assign step      = stage_valid_reg && (!stage_data_reg.final_byte || !out_valid || out_ready);
    assign in_ready  = !stage_valid_reg || step;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
            zone_offset_reg <= ZONE_OFFSET_RESET;
        end
        else begin
            if (in_ready) begin
                stage_valid_reg <= in_valid;
            end
            if (cfg_valid) begin
                zone_offset_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            stage_data_reg <= in_data;
        end
    end

    nrmc_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .item    (stage_data_reg),
        .verdict (verdict)
    );

    nrmc_hold u_hold (
        .clk         (clk),
        .rst_n       (rst_n),
        .verdict     (verdict),
        .zone_offset (zone_offset_reg),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .out_data    (out_data)
    );

endmodule

### rtl/core/nrmc_scan.sv
module nrmc_scan
    import nrmc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  nrmc_in_t      item,
    output nrmc_verdict_t verdict
);

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SENTENCE_LEN);

    logic [POS_W-1:0]           pos_reg,      pos_next;
    logic                       prefix_reg,   prefix_next;
    logic [7:0]                 xor_reg,      xor_next;
    logic                       star_reg,     star_next;
    logic [7:0]                 csum_reg,     csum_next;
    logic                       ovf_reg,      ovf_next;
    logic [1:0]                 comma_reg,    comma_next;
    logic                       status_reg,   status_next;
    logic [TIME_CHARS-1:0][3:0] digits_reg,   digits_next;

    function automatic logic [3:0] dec_digit(input logic [7:0] c);
        logic [7:0] d;
        d = c - 8'h30;
        if (c inside {[8'h30:8'h39]}) begin
            return d[3:0];
        end
        return 4'd0;
    endfunction

    // Returns {is_hex, value}.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end
        if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    logic [7:0] c;
    logic [4:0] hex;
    logic       accepted;

    always_comb
    begin
        c           = item.sentence_byte;
        hex         = hex_digit(c);
        prefix_next = prefix_reg;
        xor_next    = xor_reg;
        star_next   = star_reg;
        csum_next   = csum_reg;
        ovf_next    = ovf_reg;
        comma_next  = comma_reg;
        status_next = status_reg;
        digits_next = digits_reg;

        if (pos_reg < POS_W'(6) && c != LEAD_TEXT[pos_reg[2:0]]) begin
            prefix_next = 1'b0;
        end

        for (int i = 0; i < TIME_CHARS; i++) begin
            if (pos_reg == POS_W'(TIME_FIRST_POS + i)) begin
                digits_next[i] = dec_digit(c);
            end
        end

        if (comma_reg == 2'd2) begin
            status_next = (c == CHAR_ACTIVE);
            comma_next  = 2'd3;
        end
        else if (c == CHAR_COMMA && comma_reg < 2'd2) begin
            comma_next = comma_reg + 2'd1;
        end

        if (star_reg) begin
            if (!hex[4]) begin
                ovf_next = 1'b1;
            end
            else begin
                if (csum_reg[7:4] != 4'd0) begin
                    ovf_next = 1'b1;
                end
                csum_next = {csum_reg[3:0], hex[3:0]};
            end
        end
        else if (c == CHAR_STAR && pos_reg != '0) begin
            star_next = 1'b1;
        end
        else if (pos_reg != '0) begin
            xor_next = xor_reg ^ c;
        end

        pos_next = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;

        accepted = (pos_reg != POS_MAX) && (pos_reg >= POS_W'(5)) && prefix_next
                   && status_next && star_next && !ovf_next && (csum_next == xor_next);

        verdict.finish   = step && item.final_byte;
        verdict.accepted = accepted;
        verdict.digits   = digits_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg    <= '0;
            prefix_reg <= 1'b1;
            xor_reg    <= '0;
            star_reg   <= 1'b0;
            csum_reg   <= '0;
            ovf_reg    <= 1'b0;
            comma_reg  <= '0;
            status_reg <= 1'b0;
            digits_reg <= '0;
        end
        else if (step) begin
            if (item.final_byte) begin
                // Per-sentence state starts afresh for the next sentence.
                pos_reg    <= '0;
                prefix_reg <= 1'b1;
                xor_reg    <= '0;
                star_reg   <= 1'b0;
                csum_reg   <= '0;
                ovf_reg    <= 1'b0;
                comma_reg  <= '0;
                status_reg <= 1'b0;
                digits_reg <= '0;
            end
            else begin
                pos_reg    <= pos_next;
                prefix_reg <= prefix_next;
                xor_reg    <= xor_next;
                star_reg   <= star_next;
                csum_reg   <= csum_next;
                ovf_reg    <= ovf_next;
                comma_reg  <= comma_next;
                status_reg <= status_next;
                digits_reg <= digits_next;
            end
        end
    end

endmodule

### rtl/core/nrmc_hold.sv
module nrmc_hold
    import nrmc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  nrmc_verdict_t verdict,
    input  logic [4:0]    zone_offset,
    input  logic          out_ready,
    output logic          out_valid,
    output nrmc_out_t     out_data
);

    logic [4:0] hour_reg,   hour_next;
    logic [6:0] minute_reg, minute_next;
    logic [6:0] second_reg, second_next;
    logic       known_reg,  known_next;
    logic       out_valid_reg;
    nrmc_out_t  out_data_reg;

    function automatic logic [6:0] two_digits(input logic [3:0] tens, input logic [3:0] ones);
        logic [6:0] t;
        t = {3'b000, tens};
        return (t << 3) + (t << 1) + {3'b000, ones};
    endfunction

    logic [7:0] hour_sum;
    logic [7:0] hour_wrap;

    always_comb
    begin
        hour_sum  = {1'b0, two_digits(verdict.digits[0], verdict.digits[1])} + {3'b000, zone_offset};
        // The sum is at most 130, so three conditional subtractions reduce it below 24.
        hour_wrap = hour_sum;
        if (hour_wrap >= (HOURS_PER_DAY << 2)) begin
            hour_wrap = hour_wrap - (HOURS_PER_DAY << 2);
        end
        if (hour_wrap >= (HOURS_PER_DAY << 1)) begin
            hour_wrap = hour_wrap - (HOURS_PER_DAY << 1);
        end
        if (hour_wrap >= HOURS_PER_DAY) begin
            hour_wrap = hour_wrap - HOURS_PER_DAY;
        end

        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        known_next  = known_reg;
        if (verdict.finish && verdict.accepted) begin
            hour_next   = hour_wrap[4:0];
            minute_next = two_digits(verdict.digits[2], verdict.digits[3]);
            second_next = two_digits(verdict.digits[4], verdict.digits[5]);
            known_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
            known_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            known_reg  <= known_next;
            if (verdict.finish) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (verdict.finish) begin
            out_data_reg.sentence_accepted <= verdict.accepted;
            out_data_reg.time_known        <= known_next;
            out_data_reg.local_hour        <= hour_next;
            out_data_reg.local_minute      <= minute_next;
            out_data_reg.local_second      <= second_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/core/nrmc_checker.sv
module nrmc_checker
    import nrmc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input nrmc_out_t out_data
);

    // A stalled result must be held until the consumer takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    // An accepted sentence always leaves a known time behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.sentence_accepted |-> out_data.time_known)
        else $error("accepted sentence without known time");

    // The hour wraps inside one day.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.local_hour < 5'd24)
        else $error("local hour out of range");

    // Until a sentence is accepted the held time reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.time_known |->
            out_data.local_hour == '0 && out_data.local_minute == '0
            && out_data.local_second == '0)
        else $error("held time set before any accepted sentence");

endmodule

bind nmea_rmc_checksum_time_parser_unit nrmc_checker u_nrmc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

### sim/nmea_rmc_checksum_time_parser_unit_test.sv
module nmea_rmc_checksum_time_parser_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nrmc_pkg::*;

    // Cycles allowed for a sentence to settle after its final byte. The block
    // registers the result of a final byte, so this leaves a fair margin.
    localparam int SETTLE_CYCLES     = 8;
    // Length of the deliberate output back-pressure used to fill the block.
    localparam int LONG_HOLD_CYCLES  = 80;
    // Budget of the random part and of each of its phases.
    localparam int RANDOM_BYTES      = 40;
    localparam int RANDOM_SENTENCES  = 4;
    localparam int PHASES            = 4;
    // Absolute limit on the run, far beyond the slowest correct run.
    localparam time RUN_LIMIT        = 4ms;

    // Ways of closing a generated sentence after its data fields.
    typedef enum int {
        CKS_GOOD,
        CKS_WRONG,
        CKS_NONE,
        CKS_EMPTY,
        CKS_THREE,
        CKS_BADCHAR
    } cks_form_e;

    typedef logic [7:0] text_q_t [$];

    // Predicts the result of every sentence from the bytes that the block has
    // accepted, and checks each result that the block hands out against the
    // oldest prediction still waiting.
    class rmc_time_scoreboard;
        logic [4:0] zone_offset;
        int         position;
        bit         lead_ok;
        logic [7:0] running_xor;
        bit         star_found;
        logic [7:0] written_sum;
        bit         sum_bad;
        int         commas;
        bit         status_ok;
        logic [7:0] time_text [TIME_CHARS];
        logic [4:0] held_hour;
        logic [6:0] held_minute;
        logic [6:0] held_second;
        bit         time_known;
        nrmc_out_t  awaited_q [$];
        int         failures;

        function new();
            zone_offset = ZONE_OFFSET_RESET;
            held_hour   = '0;
            held_minute = '0;
            held_second = '0;
            time_known  = 1'b0;
            failures    = 0;
            start_sentence();
        endfunction

        function void start_sentence();
            position    = 0;
            lead_ok     = 1'b1;
            running_xor = '0;
            star_found  = 1'b0;
            written_sum = '0;
            sum_bad     = 1'b0;
            commas      = 0;
            status_ok   = 1'b0;
            foreach (time_text[i])
                time_text[i] = '0;
        endfunction

        function void set_zone_offset(logic [4:0] value);
            zone_offset = value;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        static function int hex_value(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return c - "0";
            if (c >= "A" && c <= "F")
                return c - "A" + 10;
            if (c >= "a" && c <= "f")
                return c - "a" + 10;
            return -1;
        endfunction

        static function int decimal_value(logic [7:0] c);
            return (c >= "0" && c <= "9") ? c - "0" : 0;
        endfunction

        function void note_byte(nrmc_in_t item);
            logic [7:0] c;
            int         pos;
            bit         overlong;
            bit         accepted;
            int         digit;
            int         sum;
            int         hour_utc;
            nrmc_out_t  res;

            c        = item.sentence_byte;
            pos      = position;
            overlong = pos >= MAX_SENTENCE_LEN;

            if (pos < 6 && c != LEAD_TEXT[pos])
                lead_ok = 1'b0;
            if (pos >= TIME_FIRST_POS && pos < TIME_FIRST_POS + TIME_CHARS)
                time_text[pos - TIME_FIRST_POS] = c;

            if (commas == 2)
            begin
                status_ok = (c == CHAR_ACTIVE);
                commas    = 3;
            end
            else if (c == CHAR_COMMA && commas < 2)
            begin
                commas++;
            end

            if (star_found)
            begin
                digit = hex_value(c);
                if (digit < 0)
                begin
                    sum_bad = 1'b1;
                end
                else
                begin
                    sum = (int'(written_sum) << 4) | digit;
                    if (sum > 255)
                        sum_bad = 1'b1;
                    written_sum = 8'(sum);
                end
            end
            else if (c == CHAR_STAR && pos > 0)
            begin
                star_found = 1'b1;
            end
            else if (pos > 0)
            begin
                running_xor ^= c;
            end

            if (pos < MAX_SENTENCE_LEN)
                position = pos + 1;

            if (!item.final_byte)
                return;

            accepted = !overlong && pos >= 5 && lead_ok && status_ok && star_found
                       && !sum_bad && written_sum == running_xor;
            if (accepted)
            begin
                hour_utc    = decimal_value(time_text[0]) * 10 + decimal_value(time_text[1]);
                held_hour   = 5'((hour_utc + int'(zone_offset)) % int'(HOURS_PER_DAY));
                held_minute = 7'(decimal_value(time_text[2]) * 10
                                 + decimal_value(time_text[3]));
                held_second = 7'(decimal_value(time_text[4]) * 10
                                 + decimal_value(time_text[5]));
                time_known  = 1'b1;
            end

            res.sentence_accepted = accepted;
            res.time_known        = time_known;
            res.local_hour        = held_hour;
            res.local_minute      = held_minute;
            res.local_second      = held_second;
            awaited_q.push_back(res);
            start_sentence();
        endfunction

        function void mismatch(string field, logic [7:0] want, logic [7:0] got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            failures++;
        endfunction

        function void check_result(nrmc_out_t got);
            nrmc_out_t want;

            if (awaited_q.size() == 0)
            begin
                $display("%0t: result %h arrived with nothing expected, expected none",
                         $time, got);
                failures++;
                return;
            end
            want = awaited_q.pop_front();
            if (got.sentence_accepted !== want.sentence_accepted)
                mismatch("sentence_accepted", want.sentence_accepted, got.sentence_accepted);
            if (got.time_known !== want.time_known)
                mismatch("time_known", want.time_known, got.time_known);
            if (got.local_hour !== want.local_hour)
                mismatch("local_hour", want.local_hour, got.local_hour);
            if (got.local_minute !== want.local_minute)
                mismatch("local_minute", want.local_minute, got.local_minute);
            if (got.local_second !== want.local_second)
                mismatch("local_second", want.local_second, got.local_second);
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    nrmc_in_t   in_data   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    nrmc_out_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [4:0] cfg_data  = '0;

    rmc_time_scoreboard sb = new();

    // Set by the sender for sentences that go out without any gaps.
    bit eager;
    // Handshake between the sender and the result sink for the long hold.
    bit long_hold_req;
    bit long_hold_on;
    int random_bytes;
    int random_sentences;

    nmea_rmc_checksum_time_parser_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Every result transaction is checked at the rising edge at which it is
    // taken. The values read here are those from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // The result sink. It alternates runs of readiness with stalls, mostly
    // short ones and now and then a long one. On request from the sender it
    // holds off for a long, fixed stretch so that the block fills up and has
    // to stall its input.
    initial
    begin : result_sink
        int pick;
        int run;

        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                long_hold_on  = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold_on  = 1'b0;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    out_ready <= 1'b1;
                    run = $urandom_range(1, 20);
                end
                else if (pick < 90)
                begin
                    out_ready <= 1'b0;
                    run = $urandom_range(1, 3);
                end
                else if (pick < 97)
                begin
                    out_ready <= 1'b0;
                    run = $urandom_range(4, 12);
                end
                else
                begin
                    out_ready <= 1'b0;
                    run = $urandom_range(20, 40);
                end
                repeat (run) @(negedge clk);
            end
        end
    end

    // Gap before the next byte: none in an eager sentence, otherwise mostly
    // short with the occasional long pause.
    function automatic int pick_gap();
        int pick;

        if (eager)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nibble, bit lower);
        if (nibble < 10)
            return 8'("0") + 8'(nibble);
        return (lower ? 8'("a") : 8'("A")) + 8'(nibble - 10);
    endfunction

    // A printable character for data fields; never a star, so that the
    // checksum part of a generated sentence starts where it is meant to.
    function automatic logic [7:0] field_char();
        logic [7:0] c;

        do
            c = 8'($urandom_range(8'h20, 8'h7E));
        while (c == CHAR_STAR);
        return c;
    endfunction

    // Builds an RMC sentence: the prefix, the six time characters, the status
    // byte after the second comma, some random fields, optional padding up to
    // a given total length, and then the checksum part in the requested form.
    function automatic text_q_t build_rmc(string hhmmss, logic [7:0] status, int fields,
                                          int pad_to, cks_form_e form, bit lower);
        text_q_t    s;
        logic [7:0] sum;
        logic [7:0] bad;
        int         n;

        foreach (LEAD_TEXT[i])
            s.push_back(LEAD_TEXT[i]);
        s.push_back(CHAR_COMMA);
        for (int i = 0; i < TIME_CHARS; i++)
            s.push_back(hhmmss[i]);
        s.push_back(CHAR_COMMA);
        s.push_back(status);
        repeat (fields)
        begin
            s.push_back(CHAR_COMMA);
            n = $urandom_range(0, 6);
            repeat (n)
                s.push_back(field_char());
        end
        if (pad_to > 0)
        begin
            s.push_back(CHAR_COMMA);
            while (s.size() < pad_to - 3)
                s.push_back(8'("0") + 8'($urandom_range(0, 9)));
        end

        sum = '0;
        for (int i = 1; i < s.size(); i++)
            sum ^= s[i];

        case (form)
            CKS_GOOD:
            begin
                s.push_back(CHAR_STAR);
                s.push_back(hex_char(sum[7:4], lower));
                s.push_back(hex_char(sum[3:0], lower));
            end
            CKS_WRONG:
            begin
                sum ^= 8'($urandom_range(1, 255));
                s.push_back(CHAR_STAR);
                s.push_back(hex_char(sum[7:4], lower));
                s.push_back(hex_char(sum[3:0], lower));
            end
            CKS_NONE:
            begin
            end
            CKS_EMPTY:
            begin
                s.push_back(CHAR_STAR);
            end
            CKS_THREE:
            begin
                // A leading zero keeps the value in range; anything else overflows.
                s.push_back(CHAR_STAR);
                s.push_back(hex_char(4'($urandom_range(0, 15)), lower));
                s.push_back(hex_char(sum[7:4], lower));
                s.push_back(hex_char(sum[3:0], lower));
            end
            CKS_BADCHAR:
            begin
                bad = $urandom_range(0, 1) ? CHAR_STAR : 8'("G") + 8'($urandom_range(0, 19));
                s.push_back(CHAR_STAR);
                s.push_back(hex_char(sum[7:4], lower));
                s.push_back(bad);
            end
            default:
            begin
            end
        endcase
        return s;
    endfunction

    // Offers one byte and returns at the rising edge at which it was taken.
    // Every driving task starts by moving to the next falling edge, so no
    // input is ever assigned twice in the same time step.
    task automatic send_byte(logic [7:0] b, bit last);
        int       gap;
        nrmc_in_t item;

        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item.sentence_byte = b;
        item.final_byte    = last;
        in_data  <= item;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(item);
    endtask

    task automatic send_sentence(text_q_t s);
        foreach (s[i])
            send_byte(s[i], i == s.size() - 1);
    endtask

    task automatic stop_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Waits until every predicted result has been taken, then lets the block
    // settle so that nothing is in flight.
    task automatic wait_for_results();
        stop_input();
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_zone_offset(logic [4:0] value);
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_zone_offset(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One random sentence. Most are well formed with random content and a
    // mix of checksum forms; the rest are broken copies or plain noise.
    function automatic text_q_t random_sentence();
        text_q_t    s;
        string      hhmmss;
        logic [7:0] status;
        cks_form_e  form;
        int         pick;
        int         hh;
        int         n;
        int         pad_to;

        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            n = $urandom_range(1, 24);
            repeat (n)
                s.push_back(8'($urandom_range(0, 255)));
            return s;
        end

        hh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
        hhmmss = $sformatf("%02d%02d%02d", hh, $urandom_range(0, 59), $urandom_range(0, 59));
        if ($urandom_range(0, 9) == 0)
            hhmmss[$urandom_range(0, 5)] = field_char();

        if ($urandom_range(0, 99) < 88)
            status = CHAR_ACTIVE;
        else
            status = $urandom_range(0, 1) ? 8'("V") : field_char();

        pick = $urandom_range(0, 99);
        if (pick < 72)
            form = CKS_GOOD;
        else if (pick < 78)
            form = CKS_WRONG;
        else if (pick < 83)
            form = CKS_NONE;
        else if (pick < 88)
            form = CKS_EMPTY;
        else if (pick < 94)
            form = CKS_THREE;
        else
            form = CKS_BADCHAR;

        // Now and then a sentence near the length limit, on either side of it.
        pad_to = ($urandom_range(0, 32) == 0) ? $urandom_range(120, 136) : 0;
        s = build_rmc(hhmmss, status, $urandom_range(0, 3), pad_to, form,
                      1'($urandom_range(0, 1)));

        pick = $urandom_range(0, 99);
        if (pick < 5)
            s[$urandom_range(0, 5)] ^= 8'(1 << $urandom_range(0, 7));
        else if (pick < 10)
            s = s[0:$urandom_range(0, s.size() - 1)];
        return s;
    endfunction

    // While the result sink holds off, a burst of short sentences is pushed
    // without gaps, so that results pile up inside the block and its input
    // has to stall.
    task automatic fill_under_hold();
        text_q_t s;

        stop_input();
        long_hold_req = 1'b1;
        wait (long_hold_on);
        eager = 1'b1;
        repeat (6)
        begin
            if ($urandom_range(0, 1))
                s = {8'($urandom_range(0, 255))};
            else
                s = build_rmc($sformatf("%02d%02d%02d", $urandom_range(0, 23),
                                        $urandom_range(0, 59), $urandom_range(0, 59)),
                              CHAR_ACTIVE, 0, 0, CKS_GOOD, 1'b0);
            send_sentence(s);
        end
    endtask

    initial
    begin : stimulus
        text_q_t    s;
        logic [4:0] phase_offset [PHASES];
        int         phase_bytes;
        int         phase_sentences;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the zone offset still at its reset value.
        // A short sentence comes first, so the held time is seen still unknown.
        s = {LEAD_TEXT[0], LEAD_TEXT[1], LEAD_TEXT[2]};
        send_sentence(s);
        // Single-byte sentences with every bit high and then every bit low.
        s = {8'hFF};
        send_sentence(s);
        s = {8'h00};
        send_sentence(s);
        // A plain good sentence, then one whose hour wraps past midnight,
        // with the checksum in lower case.
        send_sentence(build_rmc("123519", CHAR_ACTIVE, 2, 0, CKS_GOOD, 1'b0));
        send_sentence(build_rmc("235959", CHAR_ACTIVE, 1, 0, CKS_GOOD, 1'b1));
        // Void status, wrong checksum, no star, star without digits, three
        // digits, and a non-hex character after the star.
        send_sentence(build_rmc("101010", 8'("V"), 0, 0, CKS_GOOD, 1'b0));
        send_sentence(build_rmc("111111", CHAR_ACTIVE, 0, 0, CKS_WRONG, 1'b0));
        send_sentence(build_rmc("121212", CHAR_ACTIVE, 0, 0, CKS_NONE, 1'b0));
        send_sentence(build_rmc("131313", CHAR_ACTIVE, 0, 0, CKS_EMPTY, 1'b0));
        send_sentence(build_rmc("141414", CHAR_ACTIVE, 0, 0, CKS_THREE, 1'b0));
        send_sentence(build_rmc("151515", CHAR_ACTIVE, 0, 0, CKS_BADCHAR, 1'b0));
        // Letters among the time characters read as zero digits.
        send_sentence(build_rmc("1a2b3c", CHAR_ACTIVE, 1, 0, CKS_GOOD, 1'b0));
        // The longest sentence that passes, and one byte more.
        send_sentence(build_rmc("080808", CHAR_ACTIVE, 1, MAX_SENTENCE_LEN, CKS_GOOD, 1'b0));
        send_sentence(build_rmc("090909", CHAR_ACTIVE, 1, MAX_SENTENCE_LEN + 1,
                                CKS_GOOD, 1'b0));
        // Wrong sentence type, and a sentence that does not open with a dollar.
        s = build_rmc("161616", CHAR_ACTIVE, 1, 0, CKS_GOOD, 1'b0);
        s[5] = 8'("B");
        send_sentence(s);
        s = build_rmc("171717", CHAR_ACTIVE, 1, 0, CKS_GOOD, 1'b0);
        s[0] = 8'("X");
        send_sentence(s);
        // An hour of 99 still goes through the offset and the wrap.
        send_sentence(build_rmc("990000", CHAR_ACTIVE, 0, 0, CKS_GOOD, 1'b0));
        wait_for_results();

        // Random part in phases, each with its own zone offset. The offset is
        // only written once the block is empty. Offsets above a day are used
        // as they are, so the top of the register range is covered too.
        phase_offset[0] = 5'd0;
        phase_offset[1] = 5'd31;
        phase_offset[2] = 5'd23;
        phase_offset[3] = 5'($urandom_range(1, 30));
        for (int p = 0; p < PHASES; p++)
        begin
            write_zone_offset(phase_offset[p]);
            phase_bytes     = 0;
            phase_sentences = 0;
            if (p == 1)
                fill_under_hold();
            while (phase_bytes < RANDOM_BYTES / PHASES
                   || phase_sentences < RANDOM_SENTENCES / PHASES)
            begin
                s     = random_sentence();
                eager = ($urandom_range(0, 3) == 0);
                send_sentence(s);
                phase_bytes     += s.size();
                phase_sentences += 1;
            end
            random_bytes     += phase_bytes;
            random_sentences += phase_sentences;
            // The sender pauses here until every result of the phase is in.
            wait_for_results();
        end

        if (sb.failures == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : watchdog
        #RUN_LIMIT;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### nmea_rmc_checksum_time_parser_unit.f
rtl/core/nrmc_pkg.sv
rtl/core/nrmc_scan.sv
rtl/core/nrmc_hold.sv
rtl/core/nmea_rmc_checksum_time_parser_unit.sv
rtl/core/nrmc_checker.sv
sim/nmea_rmc_checksum_time_parser_unit_test.sv
